// ===== rtl/sensor_piecewise_linearizer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sensor piecewise linearizer
// Shared forms for the concurrent checks; they expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef SENSOR_PIECEWISE_LINEARIZER_TOP_DEFINES_SVH
`define SENSOR_PIECEWISE_LINEARIZER_TOP_DEFINES_SVH

// same-cycle implication
`define SPLZ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("splz check failed");

// next-cycle implication
`define SPLZ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("splz check failed");

`endif

// ===== rtl/splz_pkg.sv =====
// ----------------------------------------------------------------------------
// splz_pkg
// Types, codes and constants shared by the linearizer modules.
// ----------------------------------------------------------------------------
package splz_pkg;

  // 0 degC in millikelvin
  localparam logic [31:0] ZERO_C_MK = 32'd273150;

  // radix-4 restoring divide over a 66-bit dividend
  localparam int DIV_STEPS = 33;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_DIV   = 2'd1,
    ST_FEW_POINTS = 2'd2
  } status_t;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_CONVERT = 1'b1
  } kind_t;

  typedef enum logic {
    MODE_PIECEWISE = 1'b0,
    MODE_SCALAR    = 1'b1
  } mode_t;

  typedef enum logic {
    REG_MODE  = 1'b0,
    REG_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_PT0,
    S_PT1,
    S_MATH,
    S_ADJ,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL0,
    MD_MUL1,
    MD_DIV
  } md_state_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  // magnitudes for q = a * b / d
  typedef struct packed {
    logic [32:0] a;
    logic [32:0] b;
    logic [32:0] d;
  } md_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [64:0] q;
  } md_rsp_t;

  // magnitude of a 33-bit signed value, fits 33 bits unsigned
  function automatic logic [32:0] mag33(logic signed [32:0] a);
    logic signed [32:0] n;
    n = -a;
    return a[32] ? n : a;
  endfunction

endpackage

// ===== rtl/splz_if.sv =====
// ----------------------------------------------------------------------------
// splz_req_if / splz_rsp_if
// Valid/ready channels carrying request beats and result beats.
// ----------------------------------------------------------------------------
interface splz_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         entry_index;
  logic signed [31:0] entry_x;
  logic signed [31:0] entry_y;
  logic signed [31:0] sample;

  modport source (output valid, kind, entry_index, entry_x, entry_y, sample,
                  input ready);
  modport sink   (input valid, kind, entry_index, entry_x, entry_y, sample,
                  output ready);
endinterface

interface splz_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] temperature;
  logic [1:0]  status;

  modport source (output valid, temperature, status, input ready);
  modport sink   (input valid, temperature, status, output ready);
endinterface

// ===== rtl/splz_table.sv =====
// ----------------------------------------------------------------------------
// splz_table
// Point memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module splz_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  splz_pkg::point_t  wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output splz_pkg::point_t  rdata
);

  splz_pkg::point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/splz_muldiv.sv =====
// ----------------------------------------------------------------------------
// splz_muldiv
// Unsigned q = a * b / d: a multiply split into two partial products, then
// a radix-4 restoring divide, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module splz_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  splz_pkg::md_req_t req,
  output splz_pkg::md_rsp_t rsp
);

  localparam logic [5:0] LAST_STEP = 6'(splz_pkg::DIV_STEPS - 1);

  splz_pkg::md_state_t state, state_next;
  logic [32:0] a_r, b_r, d_r;
  logic [48:0] p_lo;
  logic [49:0] p_hi;
  logic [65:0] quo;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic        done_r;

  // divide: two restoring steps
  logic [33:0] r1, r1s, r2, r2s;
  logic [65:0] q1, q2;
  logic        ge1, ge2;

  always_comb begin
    r1  = {rem[32:0], quo[65]};
    ge1 = r1 >= {1'b0, d_r};
    r1s = ge1 ? r1 - {1'b0, d_r} : r1;
    q1  = {quo[64:0], ge1};
    r2  = {r1s[32:0], q1[65]};
    ge2 = r2 >= {1'b0, d_r};
    r2s = ge2 ? r2 - {1'b0, d_r} : r2;
    q2  = {q1[64:0], ge2};
  end

  // upper partial product
  assign p_hi = a_r * b_r[32:16];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      splz_pkg::MD_IDLE: if (start) state_next = splz_pkg::MD_MUL0;
      splz_pkg::MD_MUL0: state_next = splz_pkg::MD_MUL1;
      splz_pkg::MD_MUL1: state_next = splz_pkg::MD_DIV;
      splz_pkg::MD_DIV:  if (cnt == LAST_STEP) state_next = splz_pkg::MD_IDLE;
      default:           state_next = splz_pkg::MD_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.busy = (state != splz_pkg::MD_IDLE);
    rsp.done = done_r;
    rsp.q    = quo[64:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= splz_pkg::MD_IDLE;
      done_r <= 1'b0;
    end else begin
      state  <= state_next;
      done_r <= (state == splz_pkg::MD_DIV) && (cnt == LAST_STEP);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      splz_pkg::MD_IDLE: begin
        if (start) begin
          a_r <= req.a;
          b_r <= req.b;
          d_r <= req.d;
        end
      end
      splz_pkg::MD_MUL0: begin
        p_lo <= a_r * b_r[15:0];
      end
      splz_pkg::MD_MUL1: begin
        quo <= 66'(p_lo) + {p_hi, 16'd0};
        rem <= '0;
        cnt <= '0;
      end
      splz_pkg::MD_DIV: begin
        rem <= r2s;
        quo <= q2;
        cnt <= cnt + 6'd1;
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

// ===== rtl/sensor_piecewise_linearizer_top.sv =====
// ----------------------------------------------------------------------------
// sensor_piecewise_linearizer_top
// Converts voltage samples to millidegrees Celsius through a table of
// ascending (x, y) points held in a one-port-read point memory. Load beats
// write one point and produce no result. Convert beats run a binary search
// over the points, one memory read per halving, then read the chosen segment
// and compute y0 + dy*(v-x0)/dx (or v*x0/y0 in scalar mode) in a shared
// multiply/divide unit, subtract 273150 and clamp. One beat is worked at a
// time: a convert works through the search (piecewise only), the point
// reads, the multiply and the divide, which dominates. A load beat is taken
// while idle and written straight into memory. A finished result sits in an
// output register, so new beats are accepted while it waits to be taken.
// ----------------------------------------------------------------------------
`include "sensor_piecewise_linearizer_top_defines.svh"

module sensor_piecewise_linearizer_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  splz_req_if.sink           req,
  splz_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int CAP = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;

  splz_pkg::ctrl_state_t state, state_next;

  logic               mode_r;
  logic [4:0]         count_r;
  logic [4:0]         eff_count;
  logic               few;
  logic [IW-1:0]      last_idx;

  logic               acc;
  logic               is_conv;
  logic               scalar_c;
  logic signed [31:0] v_r;
  logic [IW-1:0]      lo, hi, mid_r, mid_w;
  logic               span;
  logic signed [31:0] x0_r, y0_r;
  logic [1:0]         status_r;
  logic               neg_r;
  logic [66:0]        base_r;
  logic [66:0]        t_r;

  logic               tbl_we, tbl_re;
  logic [IW-1:0]      tbl_waddr, tbl_raddr;
  splz_pkg::point_t   tbl_wdata, tbl_rdata;

  logic               md_start;
  splz_pkg::md_req_t  md_req;
  splz_pkg::md_rsp_t  md_rsp;

  logic signed [32:0] dx_w, dy_w, dv_w;
  logic               zero_y, zero_dx;

  logic               res_valid;
  logic [31:0]        res_temp;
  logic [1:0]         res_status;
  logic               res_load;
  logic [31:0]        temp_w;

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    if (paddr[2] == splz_pkg::REG_COUNT) begin
      prdata = {27'd0, count_r};
    end else begin
      prdata = {31'd0, mode_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r  <= 1'b0;
      count_r <= 5'd2;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == splz_pkg::REG_COUNT) begin
        count_r <= pwdata[4:0];
      end else begin
        mode_r <= pwdata[0];
      end
    end
  end

  // count in use and the too-few check
  always_comb begin
    eff_count = (count_r > 5'(CAP)) ? 5'(CAP) : count_r;
    few       = (mode_r == splz_pkg::MODE_PIECEWISE) ? (eff_count < 5'd2)
                                                     : (eff_count == 5'd0);
    last_idx  = IW'(eff_count - 5'd1);
  end

  assign acc     = req.valid && req.ready;
  assign is_conv = (req.kind == splz_pkg::KIND_CONVERT);

  // point loads write straight into memory
  assign tbl_we          = acc && !is_conv &&
                           ({28'd0, req.entry_index} < 32'(TABLE_DEPTH));
  assign tbl_waddr       = IW'(req.entry_index);
  assign tbl_wdata.x     = req.entry_x;
  assign tbl_wdata.y     = req.entry_y;

  // search window
  always_comb begin
    span  = {1'b0, hi} > ({1'b0, lo} + (IW+1)'(1));
    mid_w = IW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  end

  // segment arithmetic off the read data
  always_comb begin
    dx_w    = 33'(tbl_rdata.x) - 33'(x0_r);
    dy_w    = 33'(tbl_rdata.y) - 33'(y0_r);
    dv_w    = 33'(v_r) - 33'(x0_r);
    zero_y  = (tbl_rdata.y == 32'sd0);
    zero_dx = (dx_w == 33'sd0);
    if (state == splz_pkg::S_PT0) begin
      md_req.a = splz_pkg::mag33(33'(v_r));
      md_req.b = splz_pkg::mag33(33'(tbl_rdata.x));
      md_req.d = splz_pkg::mag33(33'(tbl_rdata.y));
    end else begin
      md_req.a = splz_pkg::mag33(dy_w);
      md_req.b = splz_pkg::mag33(dv_w);
      md_req.d = splz_pkg::mag33(dx_w);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      splz_pkg::S_IDLE: begin
        if (acc && is_conv) begin
          if (few) begin
            state_next = splz_pkg::S_DONE;
          end else if (mode_r == splz_pkg::MODE_SCALAR) begin
            state_next = splz_pkg::S_PT0;
          end else begin
            state_next = splz_pkg::S_SRCH;
          end
        end
      end
      splz_pkg::S_SRCH: begin
        state_next = span ? splz_pkg::S_CMP : splz_pkg::S_PT0;
      end
      splz_pkg::S_CMP: begin
        state_next = splz_pkg::S_SRCH;
      end
      splz_pkg::S_PT0: begin
        if (!scalar_c) begin
          state_next = splz_pkg::S_PT1;
        end else if (zero_y) begin
          state_next = splz_pkg::S_DONE;
        end else begin
          state_next = splz_pkg::S_MATH;
        end
      end
      splz_pkg::S_PT1: begin
        state_next = zero_dx ? splz_pkg::S_DONE : splz_pkg::S_MATH;
      end
      splz_pkg::S_MATH: begin
        if (md_rsp.done) state_next = splz_pkg::S_ADJ;
      end
      splz_pkg::S_ADJ: begin
        state_next = splz_pkg::S_DONE;
      end
      splz_pkg::S_DONE: begin
        if (!res_valid || rsp.ready) state_next = splz_pkg::S_IDLE;
      end
      default: begin
        state_next = splz_pkg::S_IDLE;
      end
    endcase
  end

  // state outputs: handshake, memory reads, unit start, result load
  always_comb begin
    req.ready = 1'b0;
    tbl_re    = 1'b0;
    tbl_raddr = '0;
    md_start  = 1'b0;
    res_load  = 1'b0;
    case (state)
      splz_pkg::S_IDLE: begin
        req.ready = 1'b1;
        tbl_re    = acc && is_conv && !few && (mode_r == splz_pkg::MODE_SCALAR);
      end
      splz_pkg::S_SRCH: begin
        tbl_re    = 1'b1;
        tbl_raddr = span ? mid_w : hi - IW'(1);
      end
      splz_pkg::S_PT0: begin
        tbl_re    = !scalar_c;
        tbl_raddr = hi;
        md_start  = scalar_c && !zero_y;
      end
      splz_pkg::S_PT1: begin
        md_start  = !zero_dx;
      end
      splz_pkg::S_DONE: begin
        res_load  = !res_valid || rsp.ready;
      end
      default: begin
        tbl_re    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= splz_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // per-item datapath
  always_ff @(posedge clk) begin
    case (state)
      splz_pkg::S_IDLE: begin
        if (acc && is_conv) begin
          v_r      <= req.sample;
          scalar_c <= (mode_r == splz_pkg::MODE_SCALAR);
          lo       <= '0;
          hi       <= last_idx;
          status_r <= few ? splz_pkg::ST_FEW_POINTS : splz_pkg::ST_OK;
        end
      end
      splz_pkg::S_SRCH: begin
        mid_r <= mid_w;
      end
      splz_pkg::S_CMP: begin
        if (tbl_rdata.x < v_r) begin
          lo <= mid_r;
        end else begin
          hi <= mid_r;
        end
      end
      splz_pkg::S_PT0: begin
        x0_r   <= tbl_rdata.x;
        y0_r   <= tbl_rdata.y;
        neg_r  <= v_r[31] ^ tbl_rdata.x[31] ^ tbl_rdata.y[31];
        base_r <= 67'd0 - 67'(splz_pkg::ZERO_C_MK);
        if (scalar_c && zero_y) status_r <= splz_pkg::ST_ZERO_DIV;
      end
      splz_pkg::S_PT1: begin
        neg_r  <= dy_w[32] ^ dv_w[32] ^ dx_w[32];
        base_r <= 67'(y0_r) - 67'(splz_pkg::ZERO_C_MK);
        if (zero_dx) status_r <= splz_pkg::ST_ZERO_DIV;
      end
      splz_pkg::S_ADJ: begin
        t_r <= neg_r ? base_r - {2'd0, md_rsp.q} : base_r + {2'd0, md_rsp.q};
      end
      default: begin
        t_r <= t_r;
      end
    endcase
  end

  // clamp to the unsigned 32-bit range; an error status gives zero
  always_comb begin
    if (status_r != splz_pkg::ST_OK || t_r[66]) begin
      temp_w = 32'd0;
    end else if (|t_r[65:32]) begin
      temp_w = 32'hFFFF_FFFF;
    end else begin
      temp_w = t_r[31:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_temp   <= temp_w;
      res_status <= status_r;
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.temperature = res_temp;
  assign rsp.status      = res_status;

  splz_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  splz_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  // checks
  `SPLZ_ASSERT_IMPL(a_mid_inside, state == splz_pkg::S_CMP, (mid_r > lo) && (mid_r < hi))
  `SPLZ_ASSERT_IMPL(a_err_temp_zero, rsp.valid && (rsp.status != splz_pkg::ST_OK), rsp.temperature == 32'd0)
  `SPLZ_ASSERT_IMPL(a_start_when_free, md_start, !md_rsp.busy)
  `SPLZ_ASSERT_NEXT(a_done_to_adj, (state == splz_pkg::S_MATH) && md_rsp.done, state == splz_pkg::S_ADJ)

endmodule

// ===== verif/tb_sensor_piecewise_linearizer_top.sv =====
// ----------------------------------------------------------------------------
// tb_sensor_piecewise_linearizer_top
// Self-checking bench for the sensor linearizer. Loads point tables, sweeps
// mode and point count over APB, converts samples in and around the table,
// and compares every result beat against an in-bench conversion model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sensor_piecewise_linearizer_top;

  // Conversion model plus queue of pending temperature/status results
  class linearize_sb;
    logic signed [31:0] pt_x[16];
    logic signed [31:0] pt_y[16];
    splz_pkg::mode_t    mode;
    logic [4:0]         count;
    logic [33:0]        temp_q[$];
    int                 errors;

    function new();
      mode   = splz_pkg::MODE_PIECEWISE;
      count  = 5'd2;
      errors = 0;
    endfunction

    function void set_reg(splz_pkg::reg_idx_t r, logic [31:0] v);
      if (r == splz_pkg::REG_MODE) mode = splz_pkg::mode_t'(v[0]);
      else count = v[4:0];
    endfunction

    // millikelvin to millidegrees C, clamped to 32 bits
    function logic [31:0] to_celsius(longint t);
      t = t - longint'(splz_pkg::ZERO_C_MK);
      if (t < 0) return 32'd0;
      if (t > longint'(32'hFFFF_FFFF)) return 32'hFFFF_FFFF;
      return t[31:0];
    endfunction

    // segment search then y0 + dy*(v-x0)/dx, exact product
    function logic [33:0] interpolate(logic signed [31:0] v, int cnt);
      int          lo, hi, mid;
      longint      x0, y0, dx, dy, dv;
      logic [66:0] mdx, mdy, mdv, q;
      bit          neg;
      lo = 0;
      hi = cnt - 1;
      while (hi - 1 > lo) begin
        mid = (lo + hi) >> 1;
        if (pt_x[mid] < v) lo = mid;
        else hi = mid;
      end
      x0 = longint'(pt_x[hi-1]);
      y0 = longint'(pt_y[hi-1]);
      dx = longint'(pt_x[hi]) - x0;
      dy = longint'(pt_y[hi]) - y0;
      if (dx == 0) return {splz_pkg::ST_ZERO_DIV, 32'd0};
      dv  = longint'(v) - x0;
      neg = ((dy < 0) != (dv < 0)) != (dx < 0);
      mdx = (dx < 0) ? -dx : dx;
      mdy = (dy < 0) ? -dy : dy;
      mdv = (dv < 0) ? -dv : dv;
      q   = (mdy * mdv) / mdx;
      if (q == 0) neg = 0;
      if (q > (67'd1 << 40)) return {splz_pkg::ST_OK, neg ? 32'd0 : 32'hFFFF_FFFF};
      return {splz_pkg::ST_OK,
              to_celsius(y0 + (neg ? -longint'(q[40:0]) : longint'(q[40:0])))};
    endfunction

    function void note_beat(splz_pkg::kind_t k, logic [3:0] idx, logic signed [31:0] x,
                            logic signed [31:0] y, logic signed [31:0] s);
      int     cnt;
      longint prod;
      if (k == splz_pkg::KIND_LOAD) begin
        pt_x[idx] = x;
        pt_y[idx] = y;
        return;
      end
      cnt = (count > 16) ? 16 : count;
      if (mode == splz_pkg::MODE_PIECEWISE) begin
        if (cnt < 2) temp_q.push_back({splz_pkg::ST_FEW_POINTS, 32'd0});
        else temp_q.push_back(interpolate(s, cnt));
      end else if (cnt < 1) begin
        temp_q.push_back({splz_pkg::ST_FEW_POINTS, 32'd0});
      end else if (pt_y[0] == 0) begin
        temp_q.push_back({splz_pkg::ST_ZERO_DIV, 32'd0});
      end else begin
        prod = longint'(s) * longint'(pt_x[0]);
        temp_q.push_back({splz_pkg::ST_OK, to_celsius(prod / longint'(pt_y[0]))});
      end
    endfunction

    function void check_result(logic [31:0] t, logic [1:0] st);
      logic [33:0] exp_r;
      if (temp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result temp=%0d status=%0d", t, st);
        return;
      end
      exp_r = temp_q.pop_front();
      if (exp_r[31:0] !== t || exp_r[33:32] !== st) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result mismatch exp temp=%0d status=%0d got temp=%0d status=%0d",
                   exp_r[31:0], exp_r[33:32], t, st);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  splz_req_if req_if();
  splz_rsp_if rsp_if();

  linearize_sb sb = new();

  int idle_pct;
  int stall_pct;
  int hold_left;
  logic signed [31:0] tbl_x[16];

  sensor_piecewise_linearizer_top u_top (
    .clk    (clk),
    .rst    (rst),
    .req    (req_if),
    .rsp    (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready)
      sb.check_result(rsp_if.temperature, rsp_if.status);
  end

  // one beat on the request channel, with random idle gaps before it
  task automatic send_beat(splz_pkg::kind_t k, logic [3:0] idx, logic signed [31:0] x,
                           logic signed [31:0] y, logic signed [31:0] s);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= k;
    req_if.entry_index <= idx;
    req_if.entry_x     <= x;
    req_if.entry_y     <= y;
    req_if.sample      <= s;
    do @(posedge clk); while (!req_if.ready);
    sb.note_beat(k, idx, x, y, s);
  endtask

  // wait for all results, then for the block to settle
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.temp_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // setup phase, access phase, then idle with psel low
  task automatic apb_write(splz_pkg::reg_idx_t r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {1'b0, r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk);
  endtask

  // fresh table: mostly ascending, sometimes with a repeated x or random x values
  task automatic load_table();
    longint base, xv;
    int     step_max, yv, style;
    base     = -longint'($urandom_range(0, 32'h4000_0000));
    step_max = ($urandom_range(0, 1)) ? 1000 : 32'h0400_0000;
    style    = $urandom_range(0, 99);
    xv       = base;
    for (int i = 0; i < 16; i++) begin
      xv += $urandom_range(1, step_max);
      if (style < 10 && i > 0 && $urandom_range(0, 7) == 0) xv = tbl_x[i-1];
      tbl_x[i] = (style >= 95) ? $urandom : xv[31:0];
      yv = (style < 60) ? 250000 + i * $urandom_range(0, 20000) : $urandom;
      send_beat(splz_pkg::KIND_LOAD, i[3:0], tbl_x[i], yv, $urandom);
    end
  endtask

  function automatic logic signed [31:0] pick_sample();
    longint lo_v, hi_v, span, v;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom;
    if (r < 25) return tbl_x[$urandom_range(0, 15)];
    lo_v = tbl_x[0];
    hi_v = tbl_x[15];
    if (hi_v < lo_v) begin
      v = lo_v; lo_v = hi_v; hi_v = v;
    end
    span = hi_v - lo_v + 1;
    v = lo_v - span / 4 + longint'({$urandom, $urandom} % (span + span / 2));
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[31:0];
  endfunction

  initial begin
    int   n_phase, r, cnt_v, mode_v;
    int   count_opts[10];
    count_opts   = '{0, 1, 2, 3, 5, 8, 15, 16, 17, 31};
    rst          = 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    req_if.valid <= 1'b0;
    req_if.kind  <= splz_pkg::KIND_LOAD;
    req_if.entry_index <= '0;
    req_if.entry_x <= '0;
    req_if.entry_y <= '0;
    req_if.sample  <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: evenly spaced table, then edges and each status code
    apb_write(splz_pkg::REG_COUNT, 32'd16);
    for (int i = 0; i < 16; i++) begin
      tbl_x[i] = -80000 + i * 10000;
      send_beat(splz_pkg::KIND_LOAD, i[3:0], tbl_x[i], 233150 + i * 5000, 0);
    end
    send_beat(splz_pkg::KIND_CONVERT, 0, 0, 0, 32'sh8000_0000);
    send_beat(splz_pkg::KIND_CONVERT, 0, 0, 0, 32'sh7FFF_FFFF);
    send_beat(splz_pkg::KIND_CONVERT, 0, 0, 0, -80000);
    send_beat(splz_pkg::KIND_CONVERT, 0, 0, 0, 12345);
    send_beat(splz_pkg::KIND_CONVERT, 0, 0, 0, 70000);
    drain();
    apb_write(splz_pkg::REG_COUNT, 32'd1);
    send_beat(splz_pkg::KIND_CONVERT, 0, 0, 0, 5);
    drain();
    apb_write(splz_pkg::REG_MODE, splz_pkg::MODE_SCALAR);
    apb_write(splz_pkg::REG_COUNT, 32'd0);
    send_beat(splz_pkg::KIND_CONVERT, 0, 0, 0, 5);
    drain();
    apb_write(splz_pkg::REG_COUNT, 32'd31);
    send_beat(splz_pkg::KIND_CONVERT, 0, 0, 0, 32'sh7FFF_FFFF);
    send_beat(splz_pkg::KIND_LOAD, 0, 32'sh8000_0000, 0, 0);
    send_beat(splz_pkg::KIND_CONVERT, 0, 0, 0, 1);
    send_beat(splz_pkg::KIND_LOAD, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF);
    tbl_x[0] = 32'sh7FFF_FFFF;
    send_beat(splz_pkg::KIND_CONVERT, 0, 0, 0, 32'sh8000_0000);
    drain();

    // random phases cycling through the idle patterns
    for (n_phase = 0; n_phase < 16; n_phase++) begin
      case (n_phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      mode_v = ($urandom_range(0, 3) == 0) ? splz_pkg::MODE_SCALAR
                                           : splz_pkg::MODE_PIECEWISE;
      cnt_v  = ($urandom_range(0, 1)) ? count_opts[$urandom_range(0, 9)]
                                      : $urandom_range(2, 16);
      if (n_phase == 0) cnt_v = 16;
      apb_write(splz_pkg::REG_MODE, mode_v);
      apb_write(splz_pkg::REG_COUNT, cnt_v);
      if ($urandom_range(0, 9) < 7) load_table();
      for (int k = 0; k < 85; k++) begin
        if (n_phase == 2 && k == 10) hold_left = 400;
        if (n_phase == 3 && k == 40) drain();
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // single point rewrite, scalar entry zero often with a zero divisor
          if (mode_v == splz_pkg::MODE_SCALAR) begin
            tbl_x[0] = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 5000);
            send_beat(splz_pkg::KIND_LOAD, 0, tbl_x[0],
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom, $urandom);
          end else begin
            r = $urandom_range(0, 15);
            tbl_x[r] = $urandom;
            send_beat(splz_pkg::KIND_LOAD, r[3:0], tbl_x[r], $urandom, $urandom);
          end
        end else begin
          send_beat(splz_pkg::KIND_CONVERT, 4'($urandom), $urandom, $urandom,
                    pick_sample());
        end
      end
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.temp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
